[hw/rtl/rqir_pkg.sv]
// ----------------------------------------------------------------------------
// rqir_pkg
// Types and constants for the indexed-remove ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rqir_pkg;

  localparam int DEPTH     = 16;
  localparam int ITEM_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ACC_W     = $clog2(2 * DEPTH);
  localparam int CFG_W     = 5;
  localparam int CMD_W     = 2;
  localparam int OFF_W     = 4;

  localparam logic [CMD_W-1:0] CMD_APPEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_OVERWRITE = 2'd3;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [OFF_W-1:0]     offset;
    logic [ITEM_BITS-1:0] item_data;
  } in_t;

  typedef struct packed {
    logic                 status;
    logic [ITEM_BITS-1:0] read_data;
    logic [CNT_W-1:0]     item_count;
    logic                 is_empty;
    logic                 is_full;
  } out_t;

endpackage

`default_nettype wire

[hw/rtl/rqir_ram.sv]
// ----------------------------------------------------------------------------
// rqir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rqir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/ring_queue_indexed_remove_unit.sv]
// One transaction in flight: in_ready is low from input accept until the result is raised.
// in_ready returns in the same cycle that out_valid is raised.
// Head, tail and position are reduced modulo the capacity by one shared subtract unit,
// one subtraction per cycle.
// Remove moves each earlier item by a RAM read, then a RAM write.
// Reset (synchronous, rst_n low) clears head, tail, count and sets capacity=16.
// ----------------------------------------------------------------------------
// ring_queue_indexed_remove_unit
// Circular queue with append, indexed remove, indexed read and overwrite,
// sequenced over one shared modulo-subtract unit and a registered-read RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_queue_indexed_remove_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rqir_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rqir_pkg::out_t                     out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rqir_pkg::CFG_W-1:0]    cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_HRED   = 8'b00000010,
    ST_TRED   = 8'b00000100,
    ST_PRED   = 8'b00001000,
    ST_RDWAIT = 8'b00010000,
    ST_MVRD   = 8'b00100000,
    ST_MVWR   = 8'b01000000,
    ST_FIN    = 8'b10000000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [rqir_pkg::CFG_W-1:0]            cap_cfg_r;
  logic [rqir_pkg::IDX_W-1:0]            head_r, head_nxt;
  logic [rqir_pkg::IDX_W-1:0]            tail_r, tail_nxt;
  logic [rqir_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [rqir_pkg::CMD_W-1:0]            cmd_r, cmd_nxt;
  logic [rqir_pkg::OFF_W-1:0]            off_r, off_nxt;
  logic [rqir_pkg::ITEM_BITS-1:0]        data_r, data_nxt;
  logic [rqir_pkg::ACC_W-1:0]            acc_r, acc_nxt;
  logic [rqir_pkg::IDX_W-1:0]            h_r, h_nxt;
  logic [rqir_pkg::IDX_W-1:0]            dst_r, dst_nxt;
  logic [rqir_pkg::OFF_W-1:0]            mv_r, mv_nxt;
  logic                                  fail_r, fail_nxt;
  logic [rqir_pkg::ITEM_BITS-1:0]        rdv_r, rdv_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  rqir_pkg::out_t                        out_data_r, out_data_nxt;

  logic [rqir_pkg::CNT_W-1:0]            cap_eff;
  logic                                  acc_ge;
  logic [rqir_pkg::ACC_W-1:0]            acc_sub;
  logic [rqir_pkg::CNT_W-1:0]            inc_val;
  logic [rqir_pkg::IDX_W-1:0]            src_idx;

  logic                                  ram_we;
  logic [rqir_pkg::IDX_W-1:0]            ram_waddr;
  logic [rqir_pkg::ITEM_BITS-1:0]        ram_wdata;
  logic [rqir_pkg::IDX_W-1:0]            ram_raddr;
  logic [rqir_pkg::ITEM_BITS-1:0]        ram_rdata;

  rqir_ram #(
    .WIDTH (rqir_pkg::ITEM_BITS),
    .DEPTH (rqir_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (cap_cfg_r == '0) begin
      cap_eff = rqir_pkg::CNT_W'(1);
    end else if (rqir_pkg::CNT_W'(cap_cfg_r) > rqir_pkg::CNT_W'(rqir_pkg::DEPTH)) begin
      cap_eff = rqir_pkg::CNT_W'(rqir_pkg::DEPTH);
    end else begin
      cap_eff = rqir_pkg::CNT_W'(cap_cfg_r);
    end
  end

  // shared modulo-reduction step
  assign acc_ge  = (acc_r >= rqir_pkg::ACC_W'(cap_eff));
  assign acc_sub = acc_r - rqir_pkg::ACC_W'(cap_eff);
  assign inc_val = rqir_pkg::CNT_W'(acc_r[rqir_pkg::IDX_W-1:0]) + rqir_pkg::CNT_W'(1);
  assign src_idx = (dst_r == '0) ? rqir_pkg::IDX_W'(cap_eff - rqir_pkg::CNT_W'(1))
                                 : dst_r - rqir_pkg::IDX_W'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    off_nxt       = off_r;
    data_nxt      = data_r;
    acc_nxt       = acc_r;
    h_nxt         = h_r;
    dst_nxt       = dst_r;
    mv_nxt        = mv_r;
    fail_nxt      = fail_r;
    rdv_nxt       = rdv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = acc_r[rqir_pkg::IDX_W-1:0];
    ram_wdata     = data_r;
    ram_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          off_nxt   = in_data.offset;
          data_nxt  = in_data.item_data;
          acc_nxt   = rqir_pkg::ACC_W'(head_r);
          fail_nxt  = 1'b1;
          rdv_nxt   = '0;
          state_nxt = ST_HRED;
        end
      end
      ST_HRED: begin
        if (acc_ge) begin
          acc_nxt = acc_sub;
        end else begin
          h_nxt = acc_r[rqir_pkg::IDX_W-1:0];
          if (cmd_r == rqir_pkg::CMD_APPEND) begin
            if (cnt_r < cap_eff) begin
              acc_nxt   = rqir_pkg::ACC_W'(tail_r);
              state_nxt = ST_TRED;
            end else begin
              state_nxt = ST_FIN;
            end
          end else if (rqir_pkg::CNT_W'(off_r) < cnt_r) begin
            acc_nxt   = acc_r + rqir_pkg::ACC_W'(off_r);
            state_nxt = ST_PRED;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_TRED: begin
        if (acc_ge) begin
          acc_nxt = acc_sub;
        end else begin
          ram_we    = 1'b1;
          tail_nxt  = (inc_val == cap_eff) ? '0 : inc_val[rqir_pkg::IDX_W-1:0];
          cnt_nxt   = cnt_r + rqir_pkg::CNT_W'(1);
          fail_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end
      end
      ST_PRED: begin
        if (acc_ge) begin
          acc_nxt = acc_sub;
        end else begin
          fail_nxt = 1'b0;
          case (cmd_r)
            rqir_pkg::CMD_READ: begin
              ram_raddr = acc_r[rqir_pkg::IDX_W-1:0];
              state_nxt = ST_RDWAIT;
            end
            rqir_pkg::CMD_OVERWRITE: begin
              ram_we    = 1'b1;
              state_nxt = ST_FIN;
            end
            default: begin
              head_nxt = ((rqir_pkg::CNT_W'(h_r) + rqir_pkg::CNT_W'(1)) == cap_eff) ?
                         '0 : h_r + rqir_pkg::IDX_W'(1);
              cnt_nxt  = cnt_r - rqir_pkg::CNT_W'(1);
              dst_nxt  = acc_r[rqir_pkg::IDX_W-1:0];
              mv_nxt   = off_r;
              state_nxt = (off_r == '0) ? ST_FIN : ST_MVRD;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        rdv_nxt   = ram_rdata;
        state_nxt = ST_FIN;
      end
      ST_MVRD: begin
        ram_raddr = src_idx;
        state_nxt = ST_MVWR;
      end
      ST_MVWR: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        dst_nxt   = src_idx;
        mv_nxt    = mv_r - rqir_pkg::OFF_W'(1);
        state_nxt = (mv_r == rqir_pkg::OFF_W'(1)) ? ST_FIN : ST_MVRD;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = fail_r;
          out_data_nxt.read_data  = rdv_r;
          out_data_nxt.item_count = cnt_r;
          out_data_nxt.is_empty   = (cnt_r == '0);
          out_data_nxt.is_full    = (cnt_r >= cap_eff);
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_cfg_r   <= rqir_pkg::CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    off_r      <= off_nxt;
    data_r     <= data_nxt;
    acc_r      <= acc_nxt;
    h_r        <= h_nxt;
    dst_r      <= dst_nxt;
    mv_r       <= mv_nxt;
    fail_r     <= fail_nxt;
    rdv_r      <= rdv_nxt;
    out_data_r <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rqir_pkg::CNT_W'(rqir_pkg::DEPTH))
    else $error("held count exceeds depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MVRD || state_r == ST_MVWR) |-> (mv_r != '0))
    else $error("move sequence with zero remaining moves");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish state");

endmodule

`default_nettype wire
